// ===== rtl/core/sxalu_pkg.sv =====
`default_nettype none

package sxalu_pkg;

	// Operand and count widths fixed by the instruction format.
	localparam int DATA_W = 16;
	localparam int CNT_W  = 5;

	// Operation codes as they arrive on the action field.
	typedef enum logic [3:0] {
		ACT_MOV = 4'd0,
		ACT_ADD = 4'd1,
		ACT_SUB = 4'd2,
		ACT_CMP = 4'd3,
		ACT_AND = 4'd4,
		ACT_OR  = 4'd5,
		ACT_XOR = 4'd6,
		ACT_NOT = 4'd7,
		ACT_SHL = 4'd8,
		ACT_SHR = 4'd9,
		ACT_RCL = 4'd10,
		ACT_RCR = 4'd11,
		ACT_MUL = 4'd12,
		ACT_DIV = 4'd13,
		ACT_INC = 4'd14,
		ACT_DEC = 4'd15
	} action_t;

	// Operations of the bit-serial add/logic lane.
	typedef enum logic [2:0] {
		BOP_ADD,
		BOP_SUB,
		BOP_AND,
		BOP_OR,
		BOP_XOR
	} bitop_t;

	// Status flags, kept between operations.
	typedef struct packed {
		logic ovf;
		logic aux;
		logic carry;
		logic sign;
		logic zero;
	} flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/sxalu_bitser.sv =====
`default_nettype none

module sxalu_bitser
	import sxalu_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire bitop_t        op,
	input  wire                wide,
	input  wire [DATA_W-1:0]   a,
	input  wire [DATA_W-1:0]   b,
	output logic               done,
	output logic [DATA_W-1:0]  res,
	output flags_t             flags
);

	logic              busy_q;
	logic              done_q;
	logic [3:0]        idx_q;
	bitop_t            op_q;
	logic              wide_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] r_q;
	logic              c_q;
	logic              any_q;
	logic              aux_q;
	logic              ovf_q;
	logic              sign_q;

	logic abit, bbit, bsel, arith_sum, arith_cout, rbit, last_bit, ovf_bit;

	// One bit of the operation per cycle, least significant bit first.
	always_comb begin
		abit       = a_q[0];
		bbit       = b_q[0];
		bsel       = (op_q == BOP_SUB) ? ~bbit : bbit;
		arith_sum  = abit ^ bsel ^ c_q;
		arith_cout = (abit & bsel) | (abit & c_q) | (bsel & c_q);
		case (op_q) inside
			BOP_ADD, BOP_SUB: rbit = arith_sum;
			BOP_AND:          rbit = abit & bbit;
			BOP_OR:           rbit = abit | bbit;
			BOP_XOR:          rbit = abit ^ bbit;
			default:          rbit = arith_sum;
		endcase
		last_bit = (idx_q == (wide_q ? 4'd15 : 4'd7));
		// Signed overflow is decided by the sign bits of operands and result.
		if (op_q == BOP_SUB) begin
			ovf_bit = (abit ^ bbit) & (abit ^ rbit);
		end else begin
			ovf_bit = ~(abit ^ bbit) & (abit ^ rbit);
		end
	end

	// Operand shift registers, carry chain flop and flag collection.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
			op_q   <= BOP_ADD;
			wide_q <= 1'b0;
			a_q    <= '0;
			b_q    <= '0;
			r_q    <= '0;
			c_q    <= 1'b0;
			any_q  <= 1'b0;
			aux_q  <= 1'b0;
			ovf_q  <= 1'b0;
			sign_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				op_q   <= op;
				wide_q <= wide;
				a_q    <= a;
				b_q    <= b;
				c_q    <= (op == BOP_SUB);
				any_q  <= 1'b0;
			end else if (busy_q) begin
				a_q   <= {1'b0, a_q[DATA_W-1:1]};
				b_q   <= {1'b0, b_q[DATA_W-1:1]};
				r_q   <= {rbit, r_q[DATA_W-1:1]};
				c_q   <= arith_cout;
				any_q <= any_q | rbit;
				idx_q <= idx_q + 4'd1;
				if (idx_q == 4'd4) begin
					aux_q <= abit ^ bbit ^ rbit;
				end
				if (last_bit) begin
					sign_q <= rbit;
					ovf_q  <= ovf_bit;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A byte operation leaves its result in the upper half of the shift register.
	assign res         = wide_q ? r_q : {8'h00, r_q[DATA_W-1:8]};
	assign done        = done_q;
	assign flags.zero  = ~any_q;
	assign flags.sign  = sign_q;
	assign flags.carry = (op_q == BOP_SUB) ? ~c_q : c_q;
	assign flags.aux   = aux_q;
	assign flags.ovf   = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/sxalu_shift.sv =====
`default_nettype none

module sxalu_shift
	import sxalu_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire action_t       act,
	input  wire                wide,
	input  wire [DATA_W-1:0]   a,
	input  wire [CNT_W-1:0]    count,
	input  wire                cf_in,
	output logic               done,
	output logic [DATA_W-1:0]  res,
	output logic               cf_out,
	output logic               of_out
);

	logic              busy_q;
	logic              done_q;
	action_t           act_q;
	logic              wide_q;
	logic [DATA_W-1:0] r_q;
	logic              c_q;
	logic [CNT_W-1:0]  left_q;

	logic [DATA_W-1:0] mask, top_mask, nxt_r;
	logic              top_bit, nxt_c, msb, below_msb;

	// One shift or rotate step per cycle.
	always_comb begin
		mask     = wide_q ? 16'hFFFF : 16'h00FF;
		top_mask = wide_q ? 16'h8000 : 16'h0080;
		top_bit  = wide_q ? r_q[15] : r_q[7];
		nxt_r    = r_q;
		nxt_c    = c_q;
		case (act_q)
			ACT_SHL: begin
				nxt_r = (r_q << 1) & mask;
				nxt_c = top_bit;
			end
			ACT_SHR: begin
				nxt_r = r_q >> 1;
				nxt_c = r_q[0];
			end
			ACT_RCL: begin
				nxt_r = ((r_q << 1) | {{(DATA_W-1){1'b0}}, c_q}) & mask;
				nxt_c = top_bit;
			end
			ACT_RCR: begin
				nxt_r = (r_q >> 1) | (c_q ? top_mask : '0);
				nxt_c = r_q[0];
			end
			default: begin
				nxt_r = r_q;
				nxt_c = c_q;
			end
		endcase
	end

	// Overflow for a single-step shift, from the final value and carry.
	always_comb begin
		msb       = wide_q ? r_q[15] : r_q[7];
		below_msb = wide_q ? r_q[14] : r_q[6];
		case (act_q) inside
			ACT_SHL, ACT_RCL: of_out = msb ^ c_q;
			ACT_SHR:          of_out = below_msb;
			default:          of_out = msb ^ below_msb;
		endcase
	end

	// Step counter; a zero count finishes at once with the operand unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			act_q  <= ACT_SHL;
			wide_q <= 1'b0;
			r_q    <= '0;
			c_q    <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				act_q  <= act;
				wide_q <= wide;
				r_q    <= a;
				c_q    <= cf_in;
				left_q <= count;
				busy_q <= (count != '0);
				done_q <= (count == '0);
			end else if (busy_q) begin
				r_q    <= nxt_r;
				c_q    <= nxt_c;
				left_q <= left_q - {{(CNT_W-1){1'b0}}, 1'b1};
				if (left_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign res    = r_q;
	assign cf_out = c_q;

endmodule

`default_nettype wire

// ===== rtl/core/sxalu_muldiv.sv =====
`default_nettype none

module sxalu_muldiv
	import sxalu_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                is_div,
	input  wire                wide,
	input  wire [DATA_W-1:0]   d,
	input  wire [DATA_W-1:0]   s,
	input  wire [DATA_W-1:0]   hi,
	output logic               done,
	output logic [DATA_W-1:0]  acc,
	output logic [DATA_W-1:0]  lo,
	output logic               div_err
);

	logic              busy_q;
	logic              done_q;
	logic              div_q;
	logic              wide_q;
	logic              err_q;
	logic [3:0]        idx_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] dv_q;

	logic [DATA_W-1:0] dvs, upper;
	logic              bad;
	logic [DATA_W:0]   mul_sum;
	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] diff;
	logic              ge;
	logic              last_step;

	// Operand setup and the up-front check for a quotient that cannot fit.
	always_comb begin
		dvs   = wide ? s : {8'h00, s[7:0]};
		upper = wide ? hi : {8'h00, d[15:8]};
		bad   = (dvs == '0) || (upper >= dvs);
	end

	// Shift-add multiply step and restoring divide step, one bit per cycle.
	always_comb begin
		mul_sum   = {1'b0, acc_q} + (lo_q[0] ? {1'b0, dv_q} : '0);
		trial     = {acc_q, lo_q[DATA_W-1]};
		diff      = {1'b0, trial} - {2'b00, dv_q};
		ge        = ~diff[DATA_W+1];
		last_step = (idx_q == (wide_q ? 4'd15 : 4'd7));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			wide_q <= 1'b0;
			err_q  <= 1'b0;
			idx_q  <= '0;
			acc_q  <= '0;
			lo_q   <= '0;
			dv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				div_q  <= is_div;
				wide_q <= wide;
				dv_q   <= dvs;
				idx_q  <= '0;
				if (is_div) begin
					acc_q  <= upper;
					lo_q   <= wide ? d : {d[7:0], 8'h00};
					err_q  <= bad;
					busy_q <= ~bad;
					done_q <= bad;
				end else begin
					acc_q  <= '0;
					lo_q   <= wide ? d : {8'h00, d[7:0]};
					err_q  <= 1'b0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				idx_q <= idx_q + 4'd1;
				if (div_q) begin
					acc_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
					lo_q  <= {lo_q[DATA_W-2:0], ge};
				end else begin
					acc_q <= mul_sum[DATA_W:1];
					lo_q  <= {mul_sum[0], lo_q[DATA_W-1:1]};
				end
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign acc     = acc_q;
	assign lo      = lo_q;
	assign div_err = err_q;

endmodule

`default_nettype wire

// ===== rtl/core/sixteen_bit_alu_with_flags_core.sv =====
`default_nettype none
// Channel  Handshake             Payload
// in       in_valid / in_stall   action, wide, dest_value, src_value, high_value, count
// out      out_valid / out_stall result, result_high, write_back, zero_flag, sign_flag,
//                                carry_flag, aux_flag, overflow_flag, divide_error
//
// An item runs N steps in its unit after its transfer: N is 8 or 16 for add,
// sub, cmp, inc, dec, logic, mov and not (one bit per cycle through the serial lane),
// 8 or 16 for mul and div (one multiplier or quotient bit per cycle), and the count
// for shifts and rotates (one step per cycle, so up to 31). A divide error ends early.
// One item is worked on at a time; the next is taken once the result sits in the
// output register, even while that result is still stalled.
// Reset clears the flags, drops out_valid and leaves in_stall low.

module sixteen_bit_alu_with_flags_core
	import sxalu_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [3:0]         action,
	input  wire                wide,
	input  wire  [DATA_W-1:0]  dest_value,
	input  wire  [DATA_W-1:0]  src_value,
	input  wire  [DATA_W-1:0]  high_value,
	input  wire  [CNT_W-1:0]   count,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [DATA_W-1:0]  result,
	output logic [DATA_W-1:0]  result_high,
	output logic               write_back,
	output logic               zero_flag,
	output logic               sign_flag,
	output logic               carry_flag,
	output logic               aux_flag,
	output logic               overflow_flag,
	output logic               divide_error
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t            state_q;
	action_t           act_q;
	logic              wide_q;
	logic [DATA_W-1:0] dest_q;
	logic [DATA_W-1:0] high_q;
	logic [CNT_W-1:0]  count_q;
	flags_t            flags_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] result_q;
	logic [DATA_W-1:0] result_high_q;
	logic              write_back_q;
	logic              divide_error_q;

	action_t           act_in;
	logic              accept;
	logic              load_out;
	logic [DATA_W-1:0] mask;
	logic              bs_start, sh_start, md_start, md_div;
	bitop_t            bs_op;
	logic [DATA_W-1:0] bs_a, bs_b;

	logic              bs_done, sh_done, md_done, unit_done;
	logic [DATA_W-1:0] bs_res, sh_res, md_acc, md_lo;
	flags_t            bs_flags;
	logic              sh_cf, sh_of, md_err, mul_cf;

	flags_t            nxt_flags;
	logic [DATA_W-1:0] nxt_result, nxt_high;
	logic              nxt_wb, nxt_derr;

	assign act_in   = action_t'(action);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign mask     = wide ? 16'hFFFF : 16'h00FF;

	// Route a transferred item to the unit that does its work.
	always_comb begin
		bs_start = 1'b0;
		sh_start = 1'b0;
		md_start = 1'b0;
		md_div   = 1'b0;
		bs_op    = BOP_ADD;
		bs_a     = dest_value & mask;
		bs_b     = src_value & mask;
		unique case (act_in) inside
			ACT_MOV: begin
				bs_start = accept;
				bs_op    = BOP_OR;
				bs_a     = '0;
			end
			ACT_ADD: begin
				bs_start = accept;
				bs_op    = BOP_ADD;
			end
			ACT_INC: begin
				bs_start = accept;
				bs_op    = BOP_ADD;
				bs_b     = {{(DATA_W-1){1'b0}}, 1'b1};
			end
			ACT_SUB, ACT_CMP: begin
				bs_start = accept;
				bs_op    = BOP_SUB;
			end
			ACT_DEC: begin
				bs_start = accept;
				bs_op    = BOP_SUB;
				bs_b     = {{(DATA_W-1){1'b0}}, 1'b1};
			end
			ACT_AND: begin
				bs_start = accept;
				bs_op    = BOP_AND;
			end
			ACT_OR: begin
				bs_start = accept;
				bs_op    = BOP_OR;
			end
			ACT_XOR: begin
				bs_start = accept;
				bs_op    = BOP_XOR;
			end
			ACT_NOT: begin
				// Complement as an exclusive-or with all ones of the width.
				bs_start = accept;
				bs_op    = BOP_XOR;
				bs_b     = mask;
			end
			ACT_SHL, ACT_SHR, ACT_RCL, ACT_RCR: begin
				sh_start = accept;
			end
			ACT_MUL: begin
				md_start = accept;
			end
			ACT_DIV: begin
				md_start = accept;
				md_div   = 1'b1;
			end
			default: begin
				bs_start = 1'b0;
			end
		endcase
	end

	sxalu_bitser u_bitser (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bs_start),
		.op     (bs_op),
		.wide   (wide),
		.a      (bs_a),
		.b      (bs_b),
		.done   (bs_done),
		.res    (bs_res),
		.flags  (bs_flags)
	);

	sxalu_shift u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sh_start),
		.act    (act_in),
		.wide   (wide),
		.a      (dest_value & mask),
		.count  (count),
		.cf_in  (flags_q.carry),
		.done   (sh_done),
		.res    (sh_res),
		.cf_out (sh_cf),
		.of_out (sh_of)
	);

	sxalu_muldiv u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (md_start),
		.is_div  (md_div),
		.wide    (wide),
		.d       (dest_value),
		.s       (src_value),
		.hi      (high_value),
		.done    (md_done),
		.acc     (md_acc),
		.lo      (md_lo),
		.div_err (md_err)
	);

	assign unit_done = bs_done | sh_done | md_done;
	assign mul_cf    = wide_q ? (md_acc != '0) : (md_acc[7:0] != 8'h00);

	// Assemble the result and the new flags from the unit that ran.
	always_comb begin
		nxt_flags  = flags_q;
		nxt_result = bs_res;
		nxt_high   = '0;
		nxt_wb     = 1'b1;
		nxt_derr   = 1'b0;
		case (act_q) inside
			ACT_ADD, ACT_SUB, ACT_CMP: begin
				nxt_flags = bs_flags;
				nxt_wb    = (act_q != ACT_CMP);
			end
			ACT_INC, ACT_DEC: begin
				nxt_flags       = bs_flags;
				nxt_flags.carry = flags_q.carry;
			end
			ACT_AND, ACT_OR, ACT_XOR: begin
				nxt_flags.zero  = bs_flags.zero;
				nxt_flags.sign  = bs_flags.sign;
				nxt_flags.carry = 1'b0;
				nxt_flags.ovf   = 1'b0;
			end
			ACT_SHL, ACT_SHR, ACT_RCL, ACT_RCR: begin
				nxt_result = sh_res;
				if (count_q != '0) begin
					nxt_flags.carry = sh_cf;
				end
				if (count_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
					nxt_flags.ovf = sh_of;
				end
			end
			ACT_MUL: begin
				nxt_result      = wide_q ? md_lo : {md_acc[7:0], md_lo[15:8]};
				nxt_high        = wide_q ? md_acc : high_q;
				nxt_flags.carry = mul_cf;
				nxt_flags.ovf   = mul_cf;
			end
			ACT_DIV: begin
				if (md_err) begin
					nxt_result      = dest_q;
					nxt_high        = high_q;
					nxt_wb          = 1'b0;
					nxt_derr        = 1'b1;
					nxt_flags.carry = 1'b1;
					nxt_flags.ovf   = 1'b1;
				end else begin
					nxt_result = wide_q ? md_lo : {md_acc[7:0], md_lo[7:0]};
					nxt_high   = wide_q ? md_acc : high_q;
				end
			end
			default: begin
				nxt_result = bs_res;
			end
		endcase
	end

	// Sequencer, flag register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			act_q          <= ACT_MOV;
			wide_q         <= 1'b0;
			dest_q         <= '0;
			high_q         <= '0;
			count_q        <= '0;
			flags_q        <= '0;
			out_valid_q    <= 1'b0;
			result_q       <= '0;
			result_high_q  <= '0;
			write_back_q   <= 1'b0;
			divide_error_q <= 1'b0;
		end else begin
			// The output register takes a new result or empties on a transfer.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q   <= act_in;
						wide_q  <= wide;
						dest_q  <= dest_value;
						high_q  <= high_value;
						count_q <= count;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (unit_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						flags_q        <= nxt_flags;
						result_q       <= nxt_result;
						result_high_q  <= nxt_high;
						write_back_q   <= nxt_wb;
						divide_error_q <= nxt_derr;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result        = result_q;
	assign result_high   = result_high_q;
	assign write_back    = write_back_q;
	assign divide_error  = divide_error_q;
	assign zero_flag     = flags_q.zero;
	assign sign_flag     = flags_q.sign;
	assign carry_flag    = flags_q.carry;
	assign aux_flag      = flags_q.aux;
	assign overflow_flag = flags_q.ovf;

	// At most one unit may finish at a time, and only while an item runs.
	a_one_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({bs_done, sh_done, md_done}))
		else $error("more than one execution unit finished at once");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		unit_done |-> (state_q == ST_RUN))
		else $error("execution unit finished outside of the run phase");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_RUN))
		else $error("transferred item did not start running");

	a_div_error_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_error) |-> (!write_back && carry_flag && overflow_flag))
		else $error("divide error without carry, overflow and blocked write-back");

endmodule

`default_nettype wire
